/* rtl/core/ccmc_pkg.sv */
// Shared types and constants for the color code module classifier.
package ccmc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULE_PIXELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_THRESHOLD = 2'd2;

  localparam int SIDE_W = 4;
  localparam int MPIX_W = 6;
  localparam int CH_W   = 8;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 4'd4;
  localparam logic [MPIX_W-1:0] MPIX_RESET = 6'd8;
  localparam logic [CH_W-1:0]   SAT_RESET  = 8'd10;

  // Per-module accumulator word: {count, v, s, h}
  localparam int SUM_W  = 18;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 3 * SUM_W + CNT_W;
  localparam int DIST_W = 18;
  localparam int SQ_W   = 2 * CH_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // Channel selects
  localparam logic [1:0] CH_H = 2'd0;
  localparam logic [1:0] CH_S = 2'd1;
  localparam logic [1:0] CH_V = 2'd2;

  typedef enum logic [3:0] {
    S_PIX,   // wait for a pixel beat
    S_UPD,   // write back module sums
    S_FRD,   // read one module's sums
    S_FLD,   // load sums, start averaging
    S_DIV,   // three serial divisions
    S_AVG,   // palette fill or start distance search
    S_MUL,   // square one channel difference
    S_ACC,   // accumulate and compare
    S_OUT    // present one result beat
  } ccmc_state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } ccmc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } ccmc_div_rsp_t;

endpackage

/* rtl/core/ccmc_pix_if.sv */
// Pixel channel: valid/ready handshake with one HSV pixel per beat.
interface ccmc_pix_if;
  import ccmc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] hue;
  logic [CH_W-1:0] saturation;
  logic [CH_W-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

/* rtl/core/ccmc_res_if.sv */
// Result channel: valid/ready handshake with one classified module per beat.
interface ccmc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] palette_index;
  logic [5:0] module_number;
  logic       last;

  modport source (output valid, palette_index, module_number, last, input ready);
  modport sink   (input valid, palette_index, module_number, last, output ready);
endinterface

/* rtl/core/color_code_module_classifier.sv */
// Color code module classifier: per-module HSV averaging and palette matching.
//
// Pixels of a square frame arrive in raster order. Each pixel takes a read of
// its module's sums from the accumulator RAM, then the write-back; no new
// pixel is taken before the write-back. After the last pixel the block
// stops taking pixels and walks the modules. Each non-corner module costs a
// RAM read and three serial divisions (18 quotient steps, then a done strobe)
// for its H/S/V averages. The divisions are skipped when no pixel passed the
// saturation threshold. Data modules then square each channel difference for
// each palette entry on one shared squarer, then wait on out_res.ready.
// Per-module valid bits clear the sums at frame start, so there
// is no clearing pass. Writing code_side or module_pixels restarts the frame;
// configuration may only be written while the block waits for pixels.
module color_code_module_classifier import ccmc_pkg::*; #(
  parameter int MAX_SIDE          = 8,
  parameter int MAX_MODULE_PIXELS = 32,
  parameter int PALETTE_SIZE      = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ccmc_pix_if.sink              in_px,
  ccmc_res_if.source            out_res
);

  localparam int MAX_MODULES = MAX_SIDE * MAX_SIDE;
  localparam int MIW = $clog2(MAX_MODULES);
  localparam int MXW = MIW + 1;
  localparam int SW  = $clog2(MAX_SIDE);
  localparam int PXW = MAX_MODULE_PIXELS > 1 ? $clog2(MAX_MODULE_PIXELS) : 1;
  localparam int PIW = $clog2(PALETTE_SIZE);
  localparam int PCW = $clog2(PALETTE_SIZE + 1);

  ccmc_state_t state_r, state_nxt;

  logic [SIDE_W-1:0] code_side_r;
  logic [MPIX_W-1:0] mpix_r;
  logic [CH_W-1:0]   thr_r;

  logic [PXW-1:0] px_r, py_r;
  logic [SW-1:0]  mc_r, mr_r;
  logic [MAX_MODULES-1:0] vld_r;

  logic [CH_W-1:0] h_r, s_r, v_r;
  logic [MIW-1:0]  m_r;
  logic            hit_r;
  logic            rd_vld_r;

  logic [MIW-1:0]  i_r;
  logic [PCW-1:0]  pal_cnt_r;
  logic [PIW-1:0]  p_r, bidx_r;
  logic [1:0]      ch_r;
  logic [WORD_W-1:0] word_r;
  logic [2:0][CH_W-1:0] avg_r;
  logic [3*CH_W-1:0] pal_mem_r [PALETTE_SIZE];
  logic [SQ_W-1:0]   sq_r;
  logic [DIST_W-1:0] acc_r, best_r, acc_nxt;

  logic [2:0] out_idx_r;
  logic [5:0] out_mod_r;
  logic       out_last_r;

  logic [SIDE_W-1:0] side_eff, side_m1;
  logic [MPIX_W-1:0] mp_eff, mp_m1;
  logic [MXW-1:0]    m_full, n_full;
  logic [MIW-1:0]    m_cur, n_m1, n_side, raddr;
  logic              col_end, row_end, frame_end, corner, last_mod;
  logic [WORD_W-1:0] rdata, word_eff, word_upd;
  logic              ram_we;
  logic [CH_W-1:0]   a_ch, b_ch, e_ch;
  logic [3*CH_W-1:0] pal_ent;
  logic              win, p_last;
  logic [PIW-1:0]    bidx_nxt;
  logic              pix_acc, res_acc;
  ccmc_div_req_t     div_req;
  ccmc_div_rsp_t     div_rsp;

  // Geometry, clamped to the supported range
  always_comb begin
    if (code_side_r < SIDE_MIN) begin
      side_eff = SIDE_MIN;
    end else if (code_side_r > SIDE_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = code_side_r;
    end
    if (mpix_r == '0) begin
      mp_eff = MPIX_W'(1);
    end else if (mpix_r > MPIX_W'(MAX_MODULE_PIXELS)) begin
      mp_eff = MPIX_W'(MAX_MODULE_PIXELS);
    end else begin
      mp_eff = mpix_r;
    end
    side_m1  = side_eff - 1'b1;
    mp_m1    = mp_eff - 1'b1;
    m_full   = MXW'(mr_r) * MXW'(side_eff) + MXW'(mc_r);
    m_cur    = m_full[MIW-1:0];
    n_full   = MXW'(side_eff) * MXW'(side_eff) - MXW'(1);
    n_m1     = n_full[MIW-1:0];
    n_side   = n_m1 - MIW'(side_m1);
    col_end  = MPIX_W'(px_r) == mp_m1 && SIDE_W'(mc_r) == side_m1;
    row_end  = MPIX_W'(py_r) == mp_m1 && SIDE_W'(mr_r) == side_m1;
    frame_end = col_end && row_end;
    corner   = i_r == '0 || i_r == MIW'(side_m1) || i_r == n_side || i_r == n_m1;
    last_mod = i_r == n_m1 - 1'b1;
  end

  // Accumulator word update for the held pixel
  always_comb begin
    word_eff = rd_vld_r ? rdata : '0;
    word_upd[SUM_W-1:0]         = word_eff[SUM_W-1:0] + SUM_W'(h_r);
    word_upd[2*SUM_W-1:SUM_W]   = word_eff[2*SUM_W-1:SUM_W] + SUM_W'(s_r);
    word_upd[3*SUM_W-1:2*SUM_W] = word_eff[3*SUM_W-1:2*SUM_W] + SUM_W'(v_r);
    word_upd[WORD_W-1:3*SUM_W]  = word_eff[WORD_W-1:3*SUM_W] + 1'b1;
  end

  ccmc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_MODULES)) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (m_r),
    .wdata (word_upd),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Divider operand selection
  always_comb begin
    div_req = '0;
    if (state_r == S_FLD) begin
      div_req.start    = word_eff[WORD_W-1:3*SUM_W] != '0;
      div_req.dividend = word_eff[SUM_W-1:0];
      div_req.divisor  = word_eff[WORD_W-1:3*SUM_W];
    end else if (state_r == S_DIV && div_rsp.done && ch_r != CH_V) begin
      div_req.start    = 1'b1;
      div_req.dividend = (ch_r == CH_H) ? word_r[2*SUM_W-1:SUM_W]
                                        : word_r[3*SUM_W-1:2*SUM_W];
      div_req.divisor  = word_r[WORD_W-1:3*SUM_W];
    end
  end

  ccmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Channel difference and distance compare
  always_comb begin
    pal_ent = pal_mem_r[p_r];
    case (ch_r)
      CH_S: begin
        a_ch = pal_ent[2*CH_W-1:CH_W];
        b_ch = avg_r[1];
      end
      CH_V: begin
        a_ch = pal_ent[3*CH_W-1:2*CH_W];
        b_ch = avg_r[2];
      end
      default: begin
        a_ch = pal_ent[CH_W-1:0];
        b_ch = avg_r[0];
      end
    endcase
    e_ch     = (a_ch >= b_ch) ? a_ch - b_ch : b_ch - a_ch;
    acc_nxt  = acc_r + DIST_W'(sq_r);
    win      = p_r == '0 || acc_nxt < best_r;
    bidx_nxt = win ? p_r : bidx_r;
    p_last   = p_r == PIW'(PALETTE_SIZE - 1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_PIX: if (in_px.valid) state_nxt = S_UPD;
      S_UPD: state_nxt = frame_end ? S_FRD : S_PIX;
      S_FRD: begin
        if (corner) begin
          if (i_r == n_m1) state_nxt = S_PIX;
        end else begin
          state_nxt = S_FLD;
        end
      end
      S_FLD: state_nxt = (word_eff[WORD_W-1:3*SUM_W] == '0) ? S_AVG : S_DIV;
      S_DIV: if (div_rsp.done && ch_r == CH_V) state_nxt = S_AVG;
      S_AVG: state_nxt = (pal_cnt_r < PCW'(PALETTE_SIZE)) ? S_FRD : S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: if (ch_r == CH_V && p_last) state_nxt = S_OUT;
             else state_nxt = S_MUL;
      S_OUT: if (out_res.ready) state_nxt = S_FRD;
      default: state_nxt = S_PIX;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_px.ready = state_r == S_PIX;
    out_res.valid = state_r == S_OUT;
    ram_we = state_r == S_UPD && hit_r;
    raddr  = (state_r == S_FRD) ? i_r : m_cur;
  end

  assign pix_acc = in_px.valid && in_px.ready;
  assign res_acc = out_res.valid && out_res.ready;
  assign out_res.palette_index = out_idx_r;
  assign out_res.module_number = out_mod_r;
  assign out_res.last          = out_last_r;

  // Control state: configuration, counters, valid bits, sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PIX;
      code_side_r <= SIDE_RESET;
      mpix_r      <= MPIX_RESET;
      thr_r       <= SAT_RESET;
      px_r <= '0; py_r <= '0; mc_r <= '0; mr_r <= '0;
      vld_r     <= '0;
      i_r       <= '0;
      pal_cnt_r <= '0;
      p_r       <= '0;
      ch_r      <= CH_H;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CODE_SIDE: begin
            code_side_r <= cfg_data[SIDE_W-1:0];
            px_r <= '0; py_r <= '0; mc_r <= '0; mr_r <= '0;
            vld_r <= '0;
          end
          CFG_MODULE_PIXELS: begin
            mpix_r <= cfg_data[MPIX_W-1:0];
            px_r <= '0; py_r <= '0; mc_r <= '0; mr_r <= '0;
            vld_r <= '0;
          end
          CFG_SAT_THRESHOLD: thr_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_UPD: begin
          // mark the module written and advance the raster position
          if (hit_r) vld_r[m_r] <= 1'b1;
          if (col_end) begin
            px_r <= '0;
            mc_r <= '0;
            if (row_end) begin
              py_r <= '0;
              mr_r <= '0;
              i_r       <= '0;
              pal_cnt_r <= '0;
            end else if (MPIX_W'(py_r) == mp_m1) begin
              py_r <= '0;
              mr_r <= mr_r + 1'b1;
            end else begin
              py_r <= py_r + 1'b1;
            end
          end else if (MPIX_W'(px_r) == mp_m1) begin
            px_r <= '0;
            mc_r <= mc_r + 1'b1;
          end else begin
            px_r <= px_r + 1'b1;
          end
        end
        S_FRD: begin
          if (corner) begin
            if (i_r == n_m1) begin
              i_r   <= '0;
              vld_r <= '0;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        S_FLD: ch_r <= CH_H;
        S_DIV: if (div_rsp.done && ch_r != CH_V) ch_r <= ch_r + 1'b1;
        S_AVG: begin
          if (pal_cnt_r < PCW'(PALETTE_SIZE)) begin
            pal_cnt_r <= pal_cnt_r + 1'b1;
            i_r       <= i_r + 1'b1;
          end else begin
            p_r  <= '0;
            ch_r <= CH_H;
          end
        end
        S_ACC: begin
          if (ch_r != CH_V) begin
            ch_r <= ch_r + 1'b1;
          end else begin
            ch_r <= CH_H;
            if (!p_last) p_r <= p_r + 1'b1;
          end
        end
        S_OUT: if (out_res.ready) i_r <= i_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[raddr];
    if (pix_acc) begin
      h_r   <= in_px.hue;
      s_r   <= in_px.saturation;
      v_r   <= in_px.brightness;
      m_r   <= m_cur;
      hit_r <= in_px.saturation > thr_r;
    end
    case (state_r)
      S_FLD: begin
        word_r <= word_eff;
        if (word_eff[WORD_W-1:3*SUM_W] == '0) avg_r <= '0;
      end
      S_DIV: if (div_rsp.done) avg_r[ch_r] <= div_rsp.quotient[CH_W-1:0];
      S_AVG: begin
        if (pal_cnt_r < PCW'(PALETTE_SIZE)) begin
          pal_mem_r[pal_cnt_r[PIW-1:0]] <= avg_r;
        end
        acc_r <= '0;
      end
      S_MUL: sq_r <= {{CH_W{1'b0}}, e_ch} * {{CH_W{1'b0}}, e_ch};
      S_ACC: begin
        if (ch_r != CH_V) begin
          acc_r <= acc_nxt;
        end else begin
          acc_r <= '0;
          if (win) begin
            best_r <= acc_nxt;
            bidx_r <= p_r;
          end
          if (p_last) begin
            out_idx_r  <= 3'(bidx_nxt);
            out_mod_r  <= 6'(i_r);
            out_last_r <= last_mod;
          end
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_pix_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    pix_acc |=> !in_px.ready)
    else $error("pixel taken on consecutive cycles");

  a_res_after_palette: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> pal_cnt_r == PCW'(PALETTE_SIZE))
    else $error("result before palette complete");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != '0)
    else $error("division by zero count");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_acc && out_res.last |=> state_r == S_FRD && corner && i_r == n_m1)
    else $error("last result not followed by final corner");

endmodule

/* rtl/core/ccmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ccmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ccmc_div.sv */
// Restoring serial divider: one quotient bit per cycle.
module ccmc_div import ccmc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ccmc_div_req_t req,
  output ccmc_div_rsp_t rsp
);

  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // One restoring step
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], fits};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
